[rtl/core/i2cram_pkg.sv]
// ----------------------------------------------------------------------------
// i2cram_pkg
// Shared types and constants for the I2C register access master.
// ----------------------------------------------------------------------------
package i2cram_pkg;

  // half-bit phases of one transaction
  typedef enum logic [4:0] {
    PH_IDLE,
    PH_ST1,
    PH_ST2,
    PH_BHI,
    PH_BLO,
    PH_AHI,
    PH_ALO,
    PH_WAIT,
    PH_RHI,
    PH_RLO,
    PH_NHI,
    PH_NLO,
    PH_SP1,
    PH_SP2
  } phase_e;

  // action codes
  localparam logic [1:0] ActTick  = 2'd0;
  localparam logic [1:0] ActWrite = 2'd1;
  localparam logic [1:0] ActRead  = 2'd2;

  // configuration register indexes
  localparam logic CfgIdxDevAddr  = 1'b0;
  localparam logic CfgIdxReadWait = 1'b1;

  // configuration reset values
  localparam logic [6:0] DevAddrRst  = 7'd116;
  localparam logic [7:0] ReadWaitRst = 8'd11;

  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  typedef struct packed {
    logic [6:0] device_address;
    logic [7:0] read_wait_ticks;
  } cfg_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_listen;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       nak_seen;
  } result_t;

endpackage

[rtl/core/i2cram_in_if.sv]
// ----------------------------------------------------------------------------
// i2cram_in_if
// Tick channel: one word per half-bit tick, carrying command and SDA sample.
// ----------------------------------------------------------------------------
interface i2cram_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] reg_addr;
  logic [7:0] write_data;
  logic       sda_sample;

  modport source (output valid, output action, output reg_addr, output write_data,
                  output sda_sample, input ready);
  modport sink   (input valid, input action, input reg_addr, input write_data,
                  input sda_sample, output ready);
endinterface

[rtl/core/i2cram_out_if.sv]
// ----------------------------------------------------------------------------
// i2cram_out_if
// Result channel: bus drive and status word for each tick.
// ----------------------------------------------------------------------------
interface i2cram_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_listen;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       nak_seen;

  modport source (output valid, output scl_level, output sda_level, output sda_listen,
                  output busy_res, output done_res, output read_data, output nak_seen,
                  input ready);
  modport sink   (input valid, input scl_level, input sda_level, input sda_listen,
                  input busy_res, input done_res, input read_data, input nak_seen,
                  output ready);
endinterface

[rtl/core/i2cram_cfg.sv]
// ----------------------------------------------------------------------------
// i2cram_cfg
// APB register file: device address and read wait ticks.
// ----------------------------------------------------------------------------
module i2cram_cfg
  import i2cram_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [6:0] dev_addr_q;
  logic [7:0] read_wait_q;
  logic       wr_en;
  logic       idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q  <= DevAddrRst;
      read_wait_q <= ReadWaitRst;
    end else if (wr_en) begin
      if (idx == CfgIdxDevAddr) begin
        dev_addr_q <= pwdata[6:0];
      end else begin
        read_wait_q <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      CfgIdxDevAddr:  prdata = {25'd0, dev_addr_q};
      CfgIdxReadWait: prdata = {24'd0, read_wait_q};
      default:        prdata = '0;
    endcase
  end

  assign cfg_o.device_address  = dev_addr_q;
  assign cfg_o.read_wait_ticks = read_wait_q;

endmodule

[rtl/core/i2cram_core.sv]
// ----------------------------------------------------------------------------
// i2cram_core
// Transaction sequencer: advances one half-bit phase per accepted tick and
// forms that tick's bus drive and status.
// ----------------------------------------------------------------------------
module i2cram_core
  import i2cram_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [1:0] action_i,
  input  logic [7:0] reg_addr_i,
  input  logic [7:0] write_data_i,
  input  logic       sda_sample_i,
  input  cfg_t       cfg_i,
  output result_t    res_o
);

  phase_e     phase_q, phase_d, ph;
  logic [2:0] bit_count_q, bit_count_d, bit_e;
  logic [1:0] byte_index_q, byte_index_d, bidx_e;
  logic [7:0] shift_q, shift_d;
  logic       is_read_q, is_read_d;
  logic [7:0] latched_reg_q, latched_reg_d;
  logic [7:0] latched_data_q, latched_data_d;
  logic [7:0] wait_q, wait_d;
  logic [7:0] read_byte_q, read_byte_d;
  logic       nak_q, nak_d;
  logic       start;
  logic [7:0] addr_byte;

  // byte to send for a given byte slot
  function automatic logic [7:0] pick_byte(input logic [1:0] bidx, input logic rd,
                                           input logic [7:0] addr, input logic [7:0] regb,
                                           input logic [7:0] datb);
    logic [7:0] b;
    if (bidx == 2'd0) begin
      b = addr;
    end else if (bidx == 2'd1) begin
      b = regb;
    end else if (rd) begin
      b = addr | 8'h01;
    end else begin
      b = datb;
    end
    return b;
  endfunction

  // a command in idle executes the first start tick right away
  assign start     = (phase_q == PH_IDLE) && ((action_i == ActWrite) || (action_i == ActRead));
  assign ph        = start ? PH_ST1 : phase_q;
  assign bidx_e    = start ? 2'd0 : byte_index_q;
  assign bit_e     = start ? 3'd0 : bit_count_q;
  assign addr_byte = {cfg_i.device_address, 1'b0};

  // next state
  always_comb begin
    phase_d        = ph;
    is_read_d      = start ? (action_i == ActRead) : is_read_q;
    latched_reg_d  = start ? reg_addr_i : latched_reg_q;
    latched_data_d = start ? write_data_i : latched_data_q;
    nak_d          = start ? 1'b0 : nak_q;
    byte_index_d   = bidx_e;
    bit_count_d    = bit_e;
    shift_d        = shift_q;
    wait_d         = wait_q;
    read_byte_d    = read_byte_q;
    case (ph)
      PH_ST1: phase_d = PH_ST2;
      PH_ST2: begin
        shift_d     = pick_byte(bidx_e, is_read_d, addr_byte, latched_reg_d, latched_data_d);
        bit_count_d = 3'd0;
        phase_d     = PH_BHI;
      end
      PH_BHI: phase_d = PH_BLO;
      PH_BLO: begin
        shift_d     = {shift_q[6:0], 1'b0};
        bit_count_d = bit_e + 3'd1;
        phase_d     = (bit_count_d == 3'd0) ? PH_AHI : PH_BHI;
      end
      PH_AHI: begin
        if (sda_sample_i) begin
          nak_d = 1'b1;
        end
        phase_d = PH_ALO;
      end
      PH_ALO: begin
        if (bidx_e == 2'd0) begin
          byte_index_d = 2'd1;
          shift_d      = pick_byte(2'd1, is_read_d, addr_byte, latched_reg_d, latched_data_d);
          bit_count_d  = 3'd0;
          phase_d      = PH_BHI;
        end else if (bidx_e == 2'd1) begin
          byte_index_d = 2'd2;
          if (is_read_d) begin
            phase_d = PH_ST1; // repeated start
          end else begin
            shift_d     = pick_byte(2'd2, is_read_d, addr_byte, latched_reg_d,
                                    latched_data_d);
            bit_count_d = 3'd0;
            phase_d     = PH_BHI;
          end
        end else if (is_read_d) begin
          shift_d     = 8'd0;
          bit_count_d = 3'd0;
          wait_d      = cfg_i.read_wait_ticks;
          phase_d     = (cfg_i.read_wait_ticks == 8'd0) ? PH_RHI : PH_WAIT;
        end else begin
          phase_d = PH_SP1;
        end
      end
      PH_WAIT: begin
        if (wait_q <= 8'd1) begin
          wait_d  = 8'd0;
          phase_d = PH_RHI;
        end else begin
          wait_d = wait_q - 8'd1;
        end
      end
      PH_RHI: begin
        shift_d = {shift_q[6:0], sda_sample_i};
        phase_d = PH_RLO;
      end
      PH_RLO: begin
        bit_count_d = bit_e + 3'd1;
        if (bit_count_d == 3'd0) begin
          read_byte_d = shift_q;
          phase_d     = PH_NHI;
        end else begin
          phase_d = PH_RHI;
        end
      end
      PH_NHI:  phase_d = PH_NLO;
      PH_NLO:  phase_d = PH_SP1;
      PH_SP1:  phase_d = PH_SP2;
      PH_SP2:  phase_d = PH_IDLE;
      default: phase_d = PH_IDLE;
    endcase
  end

  // bus drive and status
  always_comb begin
    res_o.scl_level  = 1'b1;
    res_o.sda_level  = 1'b1;
    res_o.sda_listen = 1'b0;
    res_o.busy_res   = 1'b1;
    res_o.done_res   = 1'b0;
    case (ph)
      PH_ST1: ;
      PH_ST2: res_o.sda_level = 1'b0;
      PH_BHI: res_o.sda_level = shift_q[7];
      PH_BLO: begin
        res_o.scl_level = 1'b0;
        res_o.sda_level = shift_q[7];
      end
      PH_AHI: res_o.sda_listen = 1'b1;
      PH_ALO: begin
        res_o.scl_level  = 1'b0;
        res_o.sda_listen = 1'b1;
      end
      PH_WAIT: res_o.scl_level = 1'b0;
      PH_RHI:  res_o.sda_listen = 1'b1;
      PH_RLO: begin
        res_o.scl_level  = 1'b0;
        res_o.sda_listen = 1'b1;
      end
      PH_NHI: ;
      PH_NLO: res_o.scl_level = 1'b0;
      PH_SP1: res_o.sda_level = 1'b0;
      PH_SP2: begin
        res_o.busy_res = 1'b0;
        res_o.done_res = 1'b1;
      end
      default: res_o.busy_res = 1'b0;
    endcase
    res_o.read_data = read_byte_d;
    res_o.nak_seen  = nak_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_IDLE;
      bit_count_q    <= 3'd0;
      byte_index_q   <= 2'd0;
      shift_q        <= 8'd0;
      is_read_q      <= 1'b0;
      latched_reg_q  <= 8'd0;
      latched_data_q <= 8'd0;
      wait_q         <= 8'd0;
      read_byte_q    <= 8'd0;
      nak_q          <= 1'b0;
    end else if (step_i) begin
      phase_q        <= phase_d;
      bit_count_q    <= bit_count_d;
      byte_index_q   <= byte_index_d;
      shift_q        <= shift_d;
      is_read_q      <= is_read_d;
      latched_reg_q  <= latched_reg_d;
      latched_data_q <= latched_data_d;
      wait_q         <= wait_d;
      read_byte_q    <= read_byte_d;
      nak_q          <= nak_d;
    end
  end

endmodule

[rtl/core/i2c_register_access_master.sv]
// The result word is registered and valid in the cycle after acceptance.
// Throughput: one tick word per cycle, set by the single-pass phase sequencer
// and the output register, which takes a new word while the last is taken.
// Reset: rst_ni clears the sequencer to idle, the read byte and NAK flag to
// zero, and loads device address 116 and read wait 11 ticks.
// ----------------------------------------------------------------------------
// i2c_register_access_master
// Tick-driven I2C master for single-register reads and writes.
// ----------------------------------------------------------------------------
module i2c_register_access_master
  import i2cram_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  i2cram_in_if.sink           in_i,
  i2cram_out_if.source        out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  cfg_t    cfg;
  result_t res;
  result_t res_q;
  logic    out_valid_q;
  logic    in_ready;
  logic    step;

  i2cram_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_ready   = !out_valid_q || out_o.ready;
  assign in_i.ready = in_ready;
  assign step       = in_i.valid && in_ready;

  i2cram_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .action_i     (in_i.action),
    .reg_addr_i   (in_i.reg_addr),
    .write_data_i (in_i.write_data),
    .sda_sample_i (in_i.sda_sample),
    .cfg_i        (cfg),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= step || (out_valid_q && !out_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.scl_level  = res_q.scl_level;
  assign out_o.sda_level  = res_q.sda_level;
  assign out_o.sda_listen = res_q.sda_listen;
  assign out_o.busy_res   = res_q.busy_res;
  assign out_o.done_res   = res_q.done_res;
  assign out_o.read_data  = res_q.read_data;
  assign out_o.nak_seen   = res_q.nak_seen;

endmodule
